// ----- design/tsq_pkg.sv -----
// Shared constants, codes and controller/datapath types for the two-stack queue.
`timescale 1ns / 1ps

package tsq_pkg;

    // Depth of each stack; the queue holds up to twice this many words
    localparam int STACK_DEPTH = 8;
    localparam int DATA_W      = 32;
    localparam int OP_W        = 2;
    localparam int ST_W        = 2;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Request codes
    localparam logic [OP_W-1:0] OP_ENQ   = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ   = 2'd1;
    localparam logic [OP_W-1:0] OP_FRONT = 2'd2;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MOVE_RD,
        S_MOVE_WR,
        S_POP_RD,
        S_POP_OUT
    } t_state;

    // What the result register is loaded with
    typedef enum logic [1:0] {
        RES_OK,
        RES_FULL,
        RES_EMPTY,
        RES_DATA
    } t_res_sel;

    // Controller to datapath
    typedef struct packed {
        logic     load;     // latch the request
        logic     push;     // write input stack, bump in count
        logic     mv_rd;    // read input stack top, drop in count
        logic     mv_wr;    // write read word onto output stack
        logic     top_rd;   // read output stack top
        logic     pop;      // drop out count
        logic     res_load; // present a result next cycle
        t_res_sel res_sel;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            in_full;
        logic            in_empty;
        logic            out_empty;
    } t_dp_sts;

endpackage

// ----- design/two_stack_queue.sv -----
// Sequence: a taken request is latched, then decoded; enqueue, no-op and empty answers
// load the result at once, while front/dequeue read the output stack top and then load
// it, first moving the input stack word by word onto the empty output stack (one RAM read and one RAM write each).
// A new request is taken only when idle, so one request is finished before the next
// is accepted; busy stays high until the result is
// loaded, and the next request may be taken in the cycle the result shows.
// Reset (synchronous) empties both stacks by clearing counts; storage is not cleared.
`timescale 1ns / 1ps

module two_stack_queue
    import tsq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  logic [OP_W-1:0]          i_operation,
    input  logic signed [DATA_W-1:0] i_value_in,
    output logic                     busy,
    output logic                     o_valid,
    output logic [ST_W-1:0]          o_status,
    output logic signed [DATA_W-1:0] o_value_out
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    tsq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (w_sts),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    tsq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_operation (i_operation),
        .i_value_in  (i_value_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_value_out (o_value_out)
    );

endmodule

// ----- design/tsq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/tsq_dp.sv -----
// Datapath: request latch, both stacks with their counts, and the result register.
`timescale 1ns / 1ps

module tsq_dp
    import tsq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [OP_W-1:0]          i_operation,
    input  logic signed [DATA_W-1:0] i_value_in,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    output logic                     o_valid,
    output logic [ST_W-1:0]          o_status,
    output logic signed [DATA_W-1:0] o_value_out
);

    logic [OP_W-1:0]   r_op;
    logic [DATA_W-1:0] r_word;
    logic [CNT_W-1:0]  r_in_count;
    logic [CNT_W-1:0]  r_out_count;
    logic              r_valid;
    logic [ST_W-1:0]   r_status;
    logic [DATA_W-1:0] r_value;

    logic [CNT_W-1:0]  w_in_top;
    logic [CNT_W-1:0]  w_out_top;
    logic [DATA_W-1:0] w_in_rdata;
    logic [DATA_W-1:0] w_out_rdata;
    logic [ST_W-1:0]   n_status;
    logic [DATA_W-1:0] n_value;

    assign w_in_top  = r_in_count - CNT_W'(1);
    assign w_out_top = r_out_count - CNT_W'(1);

    // Request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_word <= i_value_in;
        end
    end

    // Stack counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_count  <= '0;
            r_out_count <= '0;
        end else begin
            if (i_cmd.push) begin
                r_in_count <= r_in_count + CNT_W'(1);
            end else if (i_cmd.mv_rd) begin
                r_in_count <= w_in_top;
            end
            if (i_cmd.mv_wr) begin
                r_out_count <= r_out_count + CNT_W'(1);
            end else if (i_cmd.pop) begin
                r_out_count <= w_out_top;
            end
        end
    end

    // Input stack storage
    tsq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_in_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_in_count[ADDR_W-1:0]),
        .i_wdata (r_word),
        .i_re    (i_cmd.mv_rd),
        .i_raddr (w_in_top[ADDR_W-1:0]),
        .o_rdata (w_in_rdata)
    );

    // Output stack storage; fed from the input stack read port
    tsq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mv_wr),
        .i_waddr (r_out_count[ADDR_W-1:0]),
        .i_wdata (w_in_rdata),
        .i_re    (i_cmd.top_rd),
        .i_raddr (w_out_top[ADDR_W-1:0]),
        .o_rdata (w_out_rdata)
    );

    // Result select
    always_comb begin
        n_status = ST_OK;
        n_value  = '0;
        case (i_cmd.res_sel)
            RES_OK: begin
                n_status = ST_OK;
                n_value  = '0;
            end
            RES_FULL: begin
                n_status = ST_FULL;
                n_value  = '0;
            end
            RES_EMPTY: begin
                n_status = ST_EMPTY;
                n_value  = '1;
            end
            RES_DATA: begin
                n_status = ST_OK;
                n_value  = w_out_rdata;
            end
            default: begin
                n_status = ST_OK;
                n_value  = '0;
            end
        endcase
    end

    // Result register: one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.res_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_status <= n_status;
            r_value  <= n_value;
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.in_full   = (r_in_count == CNT_W'(STACK_DEPTH));
    assign o_sts.in_empty  = (r_in_count == '0);
    assign o_sts.out_empty = (r_out_count == '0);

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_value_out = r_value;

endmodule

// ----- design/tsq_ctrl.sv -----
// Controller: sequences push, stack transfer and pop for each request.
`timescale 1ns / 1ps

module tsq_ctrl
    import tsq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_dp_sts i_sts,
    output logic    busy,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.res_sel = RES_OK;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_sts.op) inside
                    OP_ENQ: begin
                        o_cmd.res_load = 1'b1;
                        if (i_sts.in_full) begin
                            o_cmd.res_sel = RES_FULL;
                        end else begin
                            o_cmd.push    = 1'b1;
                            o_cmd.res_sel = RES_OK;
                        end
                        n_state = S_IDLE;
                    end
                    OP_DEQ, OP_FRONT: begin
                        if (i_sts.in_empty && i_sts.out_empty) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_sel  = RES_EMPTY;
                            n_state        = S_IDLE;
                        end else if (i_sts.out_empty) begin
                            n_state = S_MOVE_RD;
                        end else begin
                            n_state = S_POP_RD;
                        end
                    end
                    default: begin
                        // unused code: no-op, plain ok result
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_sel  = RES_OK;
                        n_state        = S_IDLE;
                    end
                endcase
            end
            S_MOVE_RD: begin
                o_cmd.mv_rd = 1'b1;
                n_state     = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                o_cmd.mv_wr = 1'b1;
                // in count already reflects the word in flight
                n_state = i_sts.in_empty ? S_POP_RD : S_MOVE_RD;
            end
            S_POP_RD: begin
                o_cmd.top_rd = 1'b1;
                n_state      = S_POP_OUT;
            end
            S_POP_OUT: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_sel  = RES_DATA;
                o_cmd.pop      = (i_sts.op == OP_DEQ);
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ----- design/tsq_checker.sv -----
// Port-level checker for the two-stack queue, bound to the top level.
`timescale 1ns / 1ps

module tsq_checker
    import tsq_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     o_valid,
    input logic [ST_W-1:0]          o_status,
    input logic signed [DATA_W-1:0] o_value_out
);

    // A taken request keeps the block busy in the next cycle
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request taken but busy not raised");

    // Results come as single-cycle strobes
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // A result is shown only once the request is finished
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

    // Empty answers carry all ones
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> (o_value_out == -32'sd1))
        else $error("empty result without all-ones word");

    // Full answers carry zero
    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> (o_value_out == '0))
        else $error("full result with nonzero word");

endmodule

bind two_stack_queue tsq_checker u_tsq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_status    (o_status),
    .o_value_out (o_value_out)
);
